[hdl/frr_pkg.sv]
// frr_pkg: shared constants, state type and control structs for fold_reduce_to_range
// no dependencies; compiled first
`default_nettype none

package frr_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned WIDTH_DEF = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FOLD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic srch_load;
    logic srch_step;
    logic k_set;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic k_ok;
    logic srch_done;
    logic bnd_low;
    logic fold_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

[hdl/frr_ifs.sv]
// frr channel interfaces: source, result and bound write channels
// depends on frr_pkg for the payload width
`default_nettype none

interface frr_in_if;
  logic                        valid;
  logic                        ready;
  logic [frr_pkg::DATA_W-1:0]  source_word;
  modport source (output valid, output source_word, input ready);
  modport sink   (input valid, input source_word, output ready);
endinterface

interface frr_out_if;
  logic                        valid;
  logic                        ready;
  logic [frr_pkg::DATA_W-1:0]  mapped_value;
  modport source (output valid, output mapped_value, input ready);
  modport sink   (input valid, input mapped_value, output ready);
endinterface

interface frr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [frr_pkg::DATA_W-1:0]  bound;
  modport source (output valid, output bound, input ready);
  modport sink   (input valid, input bound, output ready);
endinterface

`default_nettype wire

[hdl/frr_ctrl.sv]
// frr_ctrl: sequencer for bound search, fold loop and result hand-off
// depends on frr_pkg (state_t, cmd_t, sts_t)
`default_nettype none

module frr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire frr_pkg::sts_t sts,
  output frr_pkg::cmd_t      cmd
);

  frr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frr_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.bnd_low) begin
            state_nxt = frr_pkg::ST_FINISH;
          end else if (sts.k_ok) begin
            state_nxt = frr_pkg::ST_FOLD;
          end else begin
            state_nxt = frr_pkg::ST_SEARCH;
          end
        end
      end
      frr_pkg::ST_SEARCH: begin
        if (sts.srch_done) begin
          state_nxt = frr_pkg::ST_FOLD;
        end
      end
      frr_pkg::ST_FOLD: begin
        if (sts.fold_done) begin
          state_nxt = frr_pkg::ST_FINISH;
        end
      end
      frr_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          state_nxt = frr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = frr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      frr_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.start     = in_valid;
        cmd.srch_load = in_valid && !sts.bnd_low && !sts.k_ok;
      end
      frr_pkg::ST_SEARCH: begin
        cmd.srch_step = !sts.srch_done;
        cmd.k_set     = sts.srch_done;
      end
      frr_pkg::ST_FOLD: begin
        cmd.step = 1'b1;
      end
      frr_pkg::ST_FINISH: begin
        cmd.emit = !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/frr_dp.sv]
// frr_dp: bound register, top-bit search, two-stage fold pipeline, result register
// depends on frr_pkg (cmd_t, sts_t, DATA_W)
`default_nettype none

module frr_dp #(
  parameter int unsigned WIDTH = frr_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire frr_pkg::cmd_t               cmd,
  output frr_pkg::sts_t                    sts,
  input  wire logic                        cfg_we,
  input  wire logic [frr_pkg::DATA_W-1:0]  cfg_data,
  input  wire logic [frr_pkg::DATA_W-1:0]  in_data,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [frr_pkg::DATA_W-1:0]       out_data
);

  localparam int unsigned KW = $clog2(WIDTH);

  logic [WIDTH-1:0] bnd_r;
  logic             kval_r;
  logic [WIDTH-1:0] sc_r;
  logic [KW-1:0]    k_r;
  logic [WIDTH-1:0] mask_r, mask_nxt;
  logic [WIDTH-1:0] src_r;
  logic             first_r;
  logic             chunk_v_r;
  logic [WIDTH-1:0] chunk_r, chunk_nxt;
  logic [WIDTH-1:0] sum_r, sum_nxt;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_r;

  logic             src_nz;
  logic             do_chunk;
  logic [WIDTH-1:0] ch;
  logic [WIDTH+1:0] diff;
  logic [WIDTH-1:0] plain;
  logic             over;

  // bound register and cached top-bit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r  <= WIDTH'(2);
      kval_r <= 1'b0;
    end else if (cfg_we) begin
      bnd_r  <= cfg_data[WIDTH-1:0];
      kval_r <= 1'b0;
    end else if (cmd.k_set) begin
      kval_r <= 1'b1;
    end
  end

  // top-bit search, one bit per cycle from the msb down
  always_ff @(posedge clk) begin
    if (cmd.srch_load) begin
      sc_r <= bnd_r;
      k_r  <= KW'(WIDTH - 1);
    end else if (cmd.srch_step) begin
      sc_r <= {sc_r[WIDTH-2:0], 1'b0};
      k_r  <= k_r - KW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < WIDTH; i++) begin
      mask_nxt[i] = (KW'(i) <= k_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_set) begin
      mask_r <= mask_nxt;
    end
  end

  // chunk stage
  assign src_nz   = |src_r;
  assign do_chunk = cmd.step && (first_r || src_nz);
  assign ch       = src_r & mask_r;
  assign chunk_nxt = (ch > bnd_r) ? (ch - bnd_r) : ch;

  // accumulate stage
  assign diff  = {2'b00, sum_r} + {2'b00, chunk_r} - {2'b00, bnd_r};
  assign plain = sum_r + chunk_r;
  assign over  = !diff[WIDTH+1] && (|diff);
  assign sum_nxt = over ? diff[WIDTH-1:0] : plain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b0;
      chunk_v_r <= 1'b0;
    end else if (cmd.start) begin
      first_r   <= 1'b1;
      chunk_v_r <= 1'b0;
    end else if (cmd.step) begin
      first_r   <= 1'b0;
      chunk_v_r <= do_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src_r <= in_data[WIDTH-1:0];
      sum_r <= '0;
    end else begin
      if (do_chunk) begin
        src_r   <= src_r >> k_r;
        chunk_r <= chunk_nxt;
      end
      if (cmd.step && chunk_v_r) begin
        sum_r <= sum_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= sts.bnd_low ? '0 : sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = frr_pkg::DATA_W'(out_r);

  assign sts.k_ok      = kval_r;
  assign sts.srch_done = sc_r[WIDTH-1];
  assign sts.bnd_low   = (bnd_r < WIDTH'(2));
  assign sts.fold_done = !first_r && !src_nz && !chunk_v_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

endmodule

`default_nettype wire

[hdl/fold_reduce_to_range.sv]
// fold_reduce_to_range: top level, joins controller and datapath to the channels
// depends on frr_pkg, frr_ifs, frr_ctrl, frr_dp
`default_nettype none

// Folds each source word into 0..bound by summing chunks of k+1 bits, k being
// the index of the bound's top set bit, reducing chunk and running sum by the
// bound once each. One item is in work at a time; the time it takes grows
// with the number of folds (1 + msb(source)/k), set by the single fold
// pipeline. After a bound write the first item also passes through the
// one-bit-per-cycle top-bit search; the index is kept for later items.
// A bound below two gives 0 without a fold. A result waits in an output
// register while the next item is taken.
module fold_reduce_to_range #(
  parameter int unsigned WIDTH = frr_pkg::WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  frr_in_if.sink     in_ch,
  frr_out_if.source  out_ch,
  frr_cfg_if.sink    cfg_ch
);

  frr_pkg::cmd_t cmd;
  frr_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  frr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frr_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_ch.valid && cfg_ch.ready),
    .cfg_data  (cfg_ch.bound),
    .in_data   (in_ch.source_word),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.mapped_value)
  );

`ifndef SYNTHESIS
  a_start_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start == (in_ch.valid && in_ch.ready))
    else $error("start not tied to input transaction");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_ch.valid && !out_ch.ready))
    else $error("result written over a pending transaction");

  a_kset_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.k_set |-> sts.srch_done)
    else $error("index taken before search finished");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("result not presented after emit");
`endif

endmodule

`default_nettype wire
